// ===== src/chc_pkg.sv =====
// ----------------------------------------------------------------------------
// chc_pkg: shared types and constants of the calibrated compass heading core
// widths, cordic word format, arctangent table, state encoding, unit status
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_RUN   = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    localparam int FIELD_W      = 16;
    localparam int HEADING_W    = 15;
    localparam int SECTOR_W     = 4;
    localparam int STATUS_W     = 8;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 72;

    // cordic word, processed one digit per cycle
    localparam int CORDIC_W     = 28;
    localparam int DIGIT_W      = 4;
    localparam int DIGITS       = CORDIC_W / DIGIT_W;
    localparam int DIG_CNT_W    = $clog2(DIGITS);
    localparam int ITER_W       = $clog2(ATAN_ENTRIES);
    localparam int BIT_IDX_W    = $clog2(CORDIC_W + ATAN_ENTRIES);
    localparam int WORD_IDX_W   = $clog2(CORDIC_W);

    localparam int QUARTER_TURN_Q16 = 5898240;
    localparam int HALF_TURN_Q6     = 11520;
    localparam int FULL_TURN_Q6     = 23040;
    localparam int HALF_SECTOR_Q6   = 720;
    localparam int ROUND_Q16_TO_Q6  = 512;
    // floor(u / 45) = (u * 1457) >> 16 for u below 1024
    localparam int SECTOR_RECIP     = 1457;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRACK,
        ST_OFFS,
        ST_ROT,
        ST_RUN,
        ST_ANGLE,
        ST_EMIT
    } chc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } chc_stat_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [CORDIC_W-1:0] atan_q16(input logic [ITER_W-1:0] idx);
        logic [CORDIC_W-1:0] v;
        case (idx)
            5'd0:    v = 28'd2949120;
            5'd1:    v = 28'd1740967;
            5'd2:    v = 28'd919879;
            5'd3:    v = 28'd466945;
            5'd4:    v = 28'd234379;
            5'd5:    v = 28'd117304;
            5'd6:    v = 28'd58666;
            5'd7:    v = 28'd29335;
            5'd8:    v = 28'd14668;
            5'd9:    v = 28'd7334;
            5'd10:   v = 28'd3667;
            5'd11:   v = 28'd1833;
            5'd12:   v = 28'd917;
            5'd13:   v = 28'd458;
            5'd14:   v = 28'd229;
            5'd15:   v = 28'd115;
            5'd16:   v = 28'd57;
            5'd17:   v = 28'd29;
            5'd18:   v = 28'd14;
            5'd19:   v = 28'd7;
            5'd20:   v = 28'd4;
            5'd21:   v = 28'd2;
            5'd22:   v = 28'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/chc_cordic.sv =====
// ----------------------------------------------------------------------------
// chc_cordic: digit-serial vectoring cordic
// each iteration walks the x, y and z words one digit per cycle, lsb first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chc_cordic (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic signed [chc_pkg::CORDIC_W-1:0] x_in,
    input  wire logic signed [chc_pkg::CORDIC_W-1:0] y_in,
    input  wire logic signed [chc_pkg::CORDIC_W-1:0] z_in,
    output chc_pkg::chc_stat_t                   stat,
    output logic signed [chc_pkg::CORDIC_W-1:0]  z_out
);
    import chc_pkg::*;

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic [DIG_CNT_W-1:0]  dig_reg, dig_next;
    logic                  dir_reg, dir_next;
    logic                  cx_reg, cy_reg, cz_reg;
    logic [CORDIC_W-1:0]   x_reg, y_reg, z_reg;
    logic [CORDIC_W-1:0]   x_acc_reg, y_acc_reg;

    logic                  first_dig, last_dig, last_iter, dir_now, y_pos;
    logic [BIT_IDX_W-1:0]  dig_off;
    logic [DIGIT_W-1:0]    sx_d, sy_d, opx, opy, opz, atan_d;
    logic [DIGIT_W:0]      sumx, sumy, sumz;
    logic                  cinx, ciny, cinz;
    logic [CORDIC_W-1:0]   atan_word;

    // bit of an arithmetic right shift, sign filled past the top
    function automatic logic shifted_bit(input logic [CORDIC_W-1:0] w,
                                         input logic [BIT_IDX_W-1:0] idx);
        logic b;
        if (idx < BIT_IDX_W'(CORDIC_W))
            b = w[idx[WORD_IDX_W-1:0]];
        else
            b = w[CORDIC_W-1];
        return b;
    endfunction

    assign first_dig = (dig_reg == '0);
    assign last_dig  = (dig_reg == DIG_CNT_W'(DIGITS - 1));
    assign last_iter = (iter_reg == ITER_W'(CORDIC_RUN - 1));
    assign y_pos     = !y_reg[CORDIC_W-1] && (y_reg != '0);
    assign dir_now   = first_dig ? y_pos : dir_reg;
    assign dig_off   = BIT_IDX_W'(dig_reg) * BIT_IDX_W'(DIGIT_W);
    assign atan_word = atan_q16(iter_reg);

    always_comb
    begin
        for (int j = 0; j < DIGIT_W; j++)
        begin
            sy_d[j] = shifted_bit(y_reg, dig_off + BIT_IDX_W'(j) + BIT_IDX_W'(iter_reg));
            sx_d[j] = shifted_bit(x_reg, dig_off + BIT_IDX_W'(j) + BIT_IDX_W'(iter_reg));
        end
    end

    assign atan_d = atan_word[dig_off[WORD_IDX_W-1:0] +: DIGIT_W];

    // y above zero: x += y>>i, y -= x>>i, z += atan; else the opposite
    assign opx  = dir_now ? sy_d   : ~sy_d;
    assign opy  = dir_now ? ~sx_d  : sx_d;
    assign opz  = dir_now ? atan_d : ~atan_d;
    assign cinx = first_dig ? !dir_now : cx_reg;
    assign ciny = first_dig ? dir_now  : cy_reg;
    assign cinz = first_dig ? !dir_now : cz_reg;

    assign sumx = {1'b0, x_reg[dig_off[WORD_IDX_W-1:0] +: DIGIT_W]} + {1'b0, opx}
                  + {{DIGIT_W{1'b0}}, cinx};
    assign sumy = {1'b0, y_reg[dig_off[WORD_IDX_W-1:0] +: DIGIT_W]} + {1'b0, opy}
                  + {{DIGIT_W{1'b0}}, ciny};
    assign sumz = {1'b0, z_reg[DIGIT_W-1:0]} + {1'b0, opz} + {{DIGIT_W{1'b0}}, cinz};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        dig_next  = dig_reg;
        dir_next  = dir_reg;
        if (start)
        begin
            run_next  = 1'b1;
            iter_next = '0;
            dig_next  = '0;
        end
        else if (run_reg)
        begin
            dir_next = dir_now;
            if (last_dig)
            begin
                dig_next = '0;
                if (last_iter)
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
                else
                    iter_next = iter_reg + 1'b1;
            end
            else
                dig_next = dig_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
            dig_reg  <= '0;
            dir_reg  <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
            dig_reg  <= dig_next;
            dir_reg  <= dir_next;
        end
    end

    // datapath words, no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        else if (run_reg)
        begin
            cx_reg <= sumx[DIGIT_W];
            cy_reg <= sumy[DIGIT_W];
            cz_reg <= sumz[DIGIT_W];
            z_reg  <= {sumz[DIGIT_W-1:0], z_reg[CORDIC_W-1:DIGIT_W]};
            if (last_dig)
            begin
                x_reg <= {sumx[DIGIT_W-1:0], x_acc_reg[CORDIC_W-1:DIGIT_W]};
                y_reg <= {sumy[DIGIT_W-1:0], y_acc_reg[CORDIC_W-1:DIGIT_W]};
            end
            else
            begin
                x_acc_reg <= {sumx[DIGIT_W-1:0], x_acc_reg[CORDIC_W-1:DIGIT_W]};
                y_acc_reg <= {sumy[DIGIT_W-1:0], y_acc_reg[CORDIC_W-1:DIGIT_W]};
            end
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign z_out     = z_reg;

`ifndef NO_ASSERTIONS
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg && $past(run_reg))
        else $error("cordic done without a finished run");
    a_digit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !run_reg |-> dig_reg == '0)
        else $error("digit counter moved while idle");
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> iter_reg <= ITER_W'(CORDIC_RUN - 1))
        else $error("cordic iteration past the last step");
`endif

endmodule

`default_nettype wire

// ===== src/compass_heading_calibrated_core.sv =====
// ----------------------------------------------------------------------------
// compass_heading_calibrated_core: hard-iron calibrated compass heading
// a beat with status bit 0 set gives one result beat after a cordic run of
// 16 iterations over 7 digits; no new sample is taken until that result is loaded for output
// a beat with status bit 0 clear is taken and gives no result
// reset: axis minimums go to 32767, maximums to -32768, no result pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module compass_heading_calibrated_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // status_byte[7:0], x_raw[23:8], y_raw[39:24], z_raw[55:40]
    input  wire logic [chc_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // heading_q6[14:0], bearing_sector[18:15], x_offset[34:19],
    // y_offset[50:35], z_offset[66:51], zero fill [71:67]
    output logic [chc_pkg::OUT_DATA_W-1:0]        m_tdata
);
    import chc_pkg::*;

    chc_state_t state_reg, state_next;

    // sample and calibration registers
    logic signed [FIELD_W-1:0]  xs_reg, ys_reg, zs_reg;
    logic signed [FIELD_W-1:0]  x_low_reg, y_low_reg, z_low_reg;
    logic signed [FIELD_W-1:0]  x_high_reg, y_high_reg, z_high_reg;
    logic signed [FIELD_W-1:0]  xo_reg, yo_reg, zo_reg;
    logic                       zero_reg;
    logic [HEADING_W-1:0]       heading_reg;
    logic                       m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]      m_data_reg;

    logic                       s_beat, new_sample;
    logic                       emit_ok;
    logic                       cordic_start;
    chc_stat_t                  cordic_stat;
    logic signed [CORDIC_W-1:0] x0, y0, z0, z_res;
    logic signed [FIELD_W:0]    dx, dy;
    logic signed [CORDIC_W-1:0] xw, yw;

    // finishing arithmetic
    logic signed [CORDIC_W-1:0] z_round, a_full;
    logic signed [FIELD_W-1:0]  a_clamp, h_full;
    logic [HEADING_W-1:0]       sector_base;
    logic [9:0]                 sector_u;
    logic [20:0]                sector_prod;
    logic [SECTOR_W-1:0]        sector;

    function automatic logic signed [FIELD_W-1:0] sample_of(input logic [FIELD_W-1:0] raw);
        return FIELD_W'($signed(raw[SAMPLE_BITS-1:0]));
    endfunction

    // (low + high) / 2 rounded toward zero
    function automatic logic signed [FIELD_W-1:0] centre(input logic signed [FIELD_W-1:0] lo,
                                                         input logic signed [FIELD_W-1:0] hi);
        logic signed [FIELD_W:0] sum;
        sum = (FIELD_W + 1)'(lo) + (FIELD_W + 1)'(hi);
        if (sum < 0)
            sum = sum + 17'sd1;
        return FIELD_W'(sum >>> 1);
    endfunction

    assign s_beat     = s_tvalid && s_tready;
    assign new_sample = s_tdata[0];
    // the output register is free or its beat goes out this cycle
    assign emit_ok    = !m_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (s_beat && new_sample)
                    state_next = ST_TRACK;
            ST_TRACK: state_next = ST_OFFS;
            ST_OFFS:  state_next = ST_ROT;
            ST_ROT:   state_next = ST_RUN;
            ST_RUN:
                if (cordic_stat.done)
                    state_next = ST_ANGLE;
            ST_ANGLE: state_next = ST_EMIT;
            ST_EMIT:
                if (emit_ok)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        s_tready     = 1'b0;
        cordic_start = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_ROT:   cordic_start = 1'b1;
            ST_EMIT:
                if (emit_ok)
                    m_valid_next = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            x_low_reg   <= 16'sh7FFF;
            y_low_reg   <= 16'sh7FFF;
            z_low_reg   <= 16'sh7FFF;
            x_high_reg  <= 16'sh8000;
            y_high_reg  <= 16'sh8000;
            z_high_reg  <= 16'sh8000;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            // minimum and maximum move independently
            if (state_reg == ST_TRACK)
            begin
                if (xs_reg > x_high_reg) x_high_reg <= xs_reg;
                if (xs_reg < x_low_reg)  x_low_reg  <= xs_reg;
                if (ys_reg > y_high_reg) y_high_reg <= ys_reg;
                if (ys_reg < y_low_reg)  y_low_reg  <= ys_reg;
                if (zs_reg > z_high_reg) z_high_reg <= zs_reg;
                if (zs_reg < z_low_reg)  z_low_reg  <= zs_reg;
            end
        end
    end

    // offset-corrected vector, scaled and turned into the right half plane
    always_comb
    begin
        dx = (FIELD_W + 1)'(xs_reg) - (FIELD_W + 1)'(xo_reg);
        dy = (FIELD_W + 1)'(ys_reg) - (FIELD_W + 1)'(yo_reg);
        xw = CORDIC_W'(dx) <<< 8;
        yw = CORDIC_W'(dy) <<< 8;
        x0 = xw;
        y0 = yw;
        z0 = '0;
        if (xw < 0)
        begin
            if (yw >= 0)
            begin
                x0 = yw;
                y0 = -xw;
                z0 = CORDIC_W'(QUARTER_TURN_Q16);
            end
            else
            begin
                x0 = -yw;
                y0 = xw;
                z0 = -CORDIC_W'(QUARTER_TURN_Q16);
            end
        end
    end

    chc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (x0),
        .y_in  (y0),
        .z_in  (z0),
        .stat  (cordic_stat),
        .z_out (z_res)
    );

    // angle rounded to 1/64 degree (zero for a zero vector), clamped to a half turn, then wrapped positive
    always_comb
    begin
        z_round = z_res + CORDIC_W'(ROUND_Q16_TO_Q6);
        a_full  = z_round >>> 10;
        if (zero_reg)
            a_clamp = '0;
        else if (a_full > CORDIC_W'(HALF_TURN_Q6))
            a_clamp = FIELD_W'(HALF_TURN_Q6);
        else if (a_full < -CORDIC_W'(HALF_TURN_Q6))
            a_clamp = -FIELD_W'(HALF_TURN_Q6);
        else
            a_clamp = FIELD_W'(a_full);
        h_full = (a_clamp > 0) ? a_clamp : a_clamp + FIELD_W'(FULL_TURN_Q6);
    end

    // sector = (heading + 720) / 1440 = ((heading + 720) >> 5) / 45, low four bits
    assign sector_base = heading_reg + HEADING_W'(HALF_SECTOR_Q6);
    assign sector_u    = sector_base[HEADING_W-1:5];
    assign sector_prod = 21'(sector_u) * 21'(SECTOR_RECIP);
    assign sector      = sector_prod[19:16];

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_beat && new_sample)
        begin
            xs_reg <= sample_of(s_tdata[23:8]);
            ys_reg <= sample_of(s_tdata[39:24]);
            zs_reg <= sample_of(s_tdata[55:40]);
        end
        if (state_reg == ST_OFFS)
        begin
            xo_reg <= centre(x_low_reg, x_high_reg);
            yo_reg <= centre(y_low_reg, y_high_reg);
            zo_reg <= centre(z_low_reg, z_high_reg);
        end
        if (state_reg == ST_ROT)
            zero_reg <= (dx == '0) && (dy == '0);
        if (state_reg == ST_ANGLE)
            heading_reg <= HEADING_W'(h_full);
        if (state_reg == ST_EMIT && emit_ok)
            m_data_reg <= {5'b0, zo_reg, yo_reg, xo_reg, sector, heading_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !cordic_stat.busy)
        else $error("sample beat taken while the cordic runs");
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_stat.done |-> state_reg == ST_RUN)
        else $error("cordic finished outside the run state");
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[14:0] != 15'd0 && m_tdata[14:0] <= 15'd23040)
        else $error("heading out of range");
    a_offsets_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OFFS |-> x_low_reg <= x_high_reg && y_low_reg <= y_high_reg)
        else $error("axis minimum above maximum after an update");
`endif

endmodule

`default_nettype wire
